FILE: hw/rtl/mecw_pkg.sv
// ----------------------------------------------------------------------------
// mecw_pkg: shared types and constants of the mecanum wheel mixer
// Fixed field widths and the control word that travels along the cell chain.
// ----------------------------------------------------------------------------
package mecw_pkg;

  localparam int LANES       = 4;
  localparam int LIMIT_W     = 15;
  localparam int OUT_W       = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1000;

  // Lane numbering follows the mix equations: w1, w2, w3, w4.
  localparam int LANE_W1 = 0;
  localparam int LANE_W2 = 1;
  localparam int LANE_W3 = 2;
  localparam int LANE_W4 = 3;

  typedef struct packed {
    logic valid;
    logic scaled;
  } ctl_t;

endpackage

FILE: hw/rtl/mecw_front.sv
// ----------------------------------------------------------------------------
// mecw_front: wheel mixing, maximum search and numerator products
// Two register stages that feed the divider chain.
// ----------------------------------------------------------------------------
module mecw_front #(
  parameter int CMD_W = 14,
  parameter int WW    = CMD_W + 2,
  parameter int NW    = WW + mecw_pkg::LIMIT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [CMD_W-1:0]       vel_x,
  input  logic signed [CMD_W-1:0]       vel_y,
  input  logic signed [CMD_W-1:0]       vel_rot,
  input  logic [mecw_pkg::LIMIT_W-1:0]  limit,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [WW-1:0]          w_o   [mecw_pkg::LANES],
  output logic signed [WW-1:0]          mx_o,
  output logic [NW-1:0]                 num_o [mecw_pkg::LANES]
);

  localparam int LN = mecw_pkg::LANES;

  logic                 a_v_r;
  logic signed [WW-1:0] a_w_r [LN];
  logic signed [WW-1:0] a_w_nxt [LN];
  logic                 a_ready;

  logic                 b_v_r;
  logic signed [WW-1:0] b_w_r  [LN];
  logic signed [WW-1:0] b_mx_r;
  logic [NW-1:0]        b_num_r [LN];
  logic signed [WW-1:0] b_mx_nxt;
  logic [NW-1:0]        b_num_nxt [LN];
  logic                 b_ready;

  logic signed [WW-1:0] ex, ey, ea, m01, m23;
  logic [WW-1:0]        mag [LN];

  assign ex = WW'(vel_x);
  assign ey = WW'(vel_y);
  assign ea = WW'(vel_rot);

  always_comb begin
    a_w_nxt[mecw_pkg::LANE_W1] = ey - ex - ea;
    a_w_nxt[mecw_pkg::LANE_W2] = ey + ex + ea;
    a_w_nxt[mecw_pkg::LANE_W3] = ey - ex + ea;
    a_w_nxt[mecw_pkg::LANE_W4] = ey + ex - ea;
  end

  assign a_ready  = !a_v_r || b_ready;
  assign b_ready  = !b_v_r || dn_ready;
  assign up_ready = a_ready;

  // Maximum over the four wheels, and |w| * limit for each lane.
  always_comb begin
    m01      = (a_w_r[0] > a_w_r[1]) ? a_w_r[0] : a_w_r[1];
    m23      = (a_w_r[2] > a_w_r[3]) ? a_w_r[2] : a_w_r[3];
    b_mx_nxt = (m01 > m23) ? m01 : m23;
    for (int l = 0; l < LN; l++) begin
      mag[l]       = a_w_r[l][WW-1] ? WW'(-a_w_r[l]) : WW'(a_w_r[l]);
      b_num_nxt[l] = NW'(mag[l]) * NW'(limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= up_valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_w_r <= a_w_nxt;
    end
    if (b_ready) begin
      b_w_r   <= a_w_r;
      b_mx_r  <= b_mx_nxt;
      b_num_r <= b_num_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign w_o      = b_w_r;
  assign mx_o     = b_mx_r;
  assign num_o    = b_num_r;

endmodule

FILE: hw/rtl/mecw_div_cell.sv
// ----------------------------------------------------------------------------
// mecw_div_cell: one step of the restoring divider, four lanes wide
// Each cell produces one quotient bit per lane and hands on to the next cell.
// ----------------------------------------------------------------------------
module mecw_div_cell #(
  parameter int WW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mecw_pkg::ctl_t        ctl_i,
  output logic                  up_ready,
  input  logic signed [WW-1:0]  w_i   [mecw_pkg::LANES],
  input  logic [WW-1:0]         div_i,
  input  logic [WW-1:0]         rem_i [mecw_pkg::LANES],
  input  logic [WW-1:0]         acc_i [mecw_pkg::LANES],
  input  logic                  dn_ready,
  output mecw_pkg::ctl_t        ctl_o,
  output logic signed [WW-1:0]  w_o   [mecw_pkg::LANES],
  output logic [WW-1:0]         div_o,
  output logic [WW-1:0]         rem_o [mecw_pkg::LANES],
  output logic [WW-1:0]         acc_o [mecw_pkg::LANES]
);

  localparam int LN = mecw_pkg::LANES;

  mecw_pkg::ctl_t       ctl_r;
  logic signed [WW-1:0] w_r   [LN];
  logic [WW-1:0]        div_r;
  logic [WW-1:0]        rem_r [LN];
  logic [WW-1:0]        acc_r [LN];
  logic [WW-1:0]        rem_nxt [LN];
  logic [WW-1:0]        acc_nxt [LN];
  logic [WW:0]          trial [LN];
  logic                 fits  [LN];

  assign up_ready = !ctl_r.valid || dn_ready;

  // Bring down the next numerator bit and subtract the divisor if it fits.
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      trial[l]   = {rem_i[l], acc_i[l][WW-1]};
      fits[l]    = trial[l] >= {1'b0, div_i};
      rem_nxt[l] = fits[l] ? WW'(trial[l] - {1'b0, div_i}) : trial[l][WW-1:0];
      acc_nxt[l] = {acc_i[l][WW-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      w_r   <= w_i;
      div_r <= div_i;
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign w_o   = w_r;
  assign div_o = div_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;

endmodule

FILE: hw/rtl/mecw_skid.sv
// ----------------------------------------------------------------------------
// mecw_skid: two-entry output buffer
// Holds the result on the output while a spare entry keeps upstream moving.
// ----------------------------------------------------------------------------
module mecw_skid #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [DW-1:0] up_data,
  input  logic          up_user,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [DW-1:0] dn_data,
  output logic          dn_user
);

  logic          out_v_r, spare_v_r;
  logic [DW-1:0] out_d_r, spare_d_r;
  logic          out_u_r, spare_u_r;
  logic          take;

  assign up_ready = !spare_v_r;
  assign take     = up_valid && !spare_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!out_v_r || dn_ready) begin
      out_v_r   <= spare_v_r || take;
      spare_v_r <= 1'b0;
    end else if (take) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || dn_ready) begin
      out_d_r <= spare_v_r ? spare_d_r : up_data;
      out_u_r <= spare_v_r ? spare_u_r : up_user;
    end else if (take) begin
      spare_d_r <= up_data;
      spare_u_r <= up_user;
    end
  end

  assign dn_valid = out_v_r;
  assign dn_data  = out_d_r;
  assign dn_user  = out_u_r;

endmodule

FILE: hw/rtl/mecanum_wheel_mixer_top.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_top: mecanum inverse kinematics with speed limiting
// Mixes a body velocity request into four wheel speeds and rescales them all
// when the largest exceeds the configured limit.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------------
//  in_      | slave     | tdata: vel_x, vel_y, vel_rot (CMD_WIDTH bits each)
//  out_     | master    | tdata: motor_one..motor_four (16 bits); tuser: flag
//  cfg_     | write     | speed_limit (15 bits, unsigned)
//
// One request is taken per cycle while the pipeline is not stalled. Each
// request passes through two front stages (mixing, then maximum and the
// |w| * limit products), one divider cell per quotient bit (CMD_WIDTH + 2
// cells), and the output register.
// Reset clears every valid bit and loads the speed limit with 1000; no
// memory needs clearing. A stall on the output is absorbed by a spare entry
// behind the output register, and backpressure reaches the input only once
// every stage ahead of it is occupied.
//
// Wheels are w1 = y-x-a, w2 = y+x+a, w3 = y-x+a, w4 = y+x-a. When the largest
// wheel is above the limit each becomes w*limit/max, rounded toward zero;
// strongly negative wheels are not limited. The scaled magnitudes are formed
// by a restoring divider whose cells each resolve one quotient bit for all
// four lanes against the shared divisor (the maximum).
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top #(
  parameter int CMD_WIDTH = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata, lowest bit up: vel_x, vel_y, vel_rot, zero padding
  input  logic [((3*CMD_WIDTH+7)/8)*8-1:0]  in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, lowest bit up: motor_one, motor_two, motor_three, motor_four
  output logic [4*mecw_pkg::OUT_W-1:0]      out_tdata,
  // tuser: was_scaled
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [mecw_pkg::LIMIT_W-1:0]      cfg_wr_data
);

  localparam int LN  = mecw_pkg::LANES;
  localparam int LW  = mecw_pkg::LIMIT_W;
  localparam int OW  = mecw_pkg::OUT_W;
  localparam int WW  = CMD_WIDTH + 2;      // wheel width, also quotient width
  localparam int NW  = WW + LW;            // numerator |w| * limit
  localparam int NC  = WW;                 // one cell per quotient bit
  localparam int CW  = (WW > LW + 1) ? WW : LW + 1;

  // Speed limit register; the user must write it only while the block is idle, which the block does not enforce.
  logic [LW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mecw_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Front end: mixing, maximum and numerators.
  logic                 f_valid;
  logic signed [WW-1:0] f_w  [LN];
  logic signed [WW-1:0] f_mx;
  logic [NW-1:0]        f_num [LN];

  // Cell chain nodes: node k feeds cell k, node NC is the chain output.
  mecw_pkg::ctl_t       c_ctl [NC+1];
  logic                 c_rdy [NC+1];
  logic signed [WW-1:0] c_w   [NC+1][LN];
  logic [WW-1:0]        c_div [NC+1];
  logic [WW-1:0]        c_rem [NC+1][LN];
  logic [WW-1:0]        c_acc [NC+1][LN];

  mecw_front #(
    .CMD_W (CMD_WIDTH),
    .WW    (WW),
    .NW    (NW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .vel_x    (in_tdata[CMD_WIDTH-1:0]),
    .vel_y    (in_tdata[2*CMD_WIDTH-1:CMD_WIDTH]),
    .vel_rot  (in_tdata[3*CMD_WIDTH-1:2*CMD_WIDTH]),
    .limit    (limit_r),
    .dn_valid (f_valid),
    .dn_ready (c_rdy[0]),
    .w_o      (f_w),
    .mx_o     (f_mx),
    .num_o    (f_num)
  );

  // Scaling applies only when the maximum is strictly above the limit; the
  // divisor is then positive, so its bit pattern is used unsigned.
  logic signed [CW-1:0] mx_ext, lim_ext;

  assign mx_ext  = CW'(f_mx);
  assign lim_ext = CW'(signed'({1'b0, limit_r}));

  always_comb begin
    c_ctl[0].valid  = f_valid;
    c_ctl[0].scaled = mx_ext > lim_ext;
    c_div[0]        = WW'(f_mx);
    for (int l = 0; l < LN; l++) begin
      c_w[0][l]   = f_w[l];
      c_rem[0][l] = WW'(f_num[l][NW-1:WW]);
      c_acc[0][l] = f_num[l][WW-1:0];
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    mecw_div_cell #(
      .WW (WW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (c_ctl[k]),
      .up_ready (c_rdy[k]),
      .w_i      (c_w[k]),
      .div_i    (c_div[k]),
      .rem_i    (c_rem[k]),
      .acc_i    (c_acc[k]),
      .dn_ready (c_rdy[k+1]),
      .ctl_o    (c_ctl[k+1]),
      .w_o      (c_w[k+1]),
      .div_o    (c_div[k+1]),
      .rem_o    (c_rem[k+1]),
      .acc_o    (c_acc[k+1])
    );
  end

  // Apply the sign of each wheel to its quotient, or pass the wheel through.
  logic signed [WW-1:0] q_s  [LN];
  logic signed [WW-1:0] sel  [LN];
  logic [OW-1:0]        res  [LN];
  logic [4*OW-1:0]      pay;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      q_s[l] = signed'(c_acc[NC][l]);
      if (c_ctl[NC].scaled) begin
        sel[l] = c_w[NC][l][WW-1] ? -q_s[l] : q_s[l];
      end else begin
        sel[l] = c_w[NC][l];
      end
      res[l] = OW'(sel[l]);
    end
    // Motor order on the output is w1, w2, w4, w3.
    pay = {res[mecw_pkg::LANE_W3], res[mecw_pkg::LANE_W4],
           res[mecw_pkg::LANE_W2], res[mecw_pkg::LANE_W1]};
  end

  mecw_skid #(
    .DW (4*OW)
  ) u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_ctl[NC].valid),
    .up_ready (c_rdy[NC]),
    .up_data  (pay),
    .up_user  (c_ctl[NC].scaled),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata),
    .dn_user  (out_tuser)
  );

endmodule

FILE: hw/rtl/mecw_checker.sv
// ----------------------------------------------------------------------------
// mecw_checker: port-level checks for the mecanum wheel mixer
// Tracks requests in flight and checks output stalls and input readiness.
// ----------------------------------------------------------------------------
module mecw_checker #(
  parameter int CMD_WIDTH = 14
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [4*mecw_pkg::OUT_W-1:0] out_tdata,
  input logic                         out_tuser
);

  // Two front stages, one cell per quotient bit, output and spare entries.
  localparam int CAP   = 2 + (CMD_WIDTH + 2) + 2;
  localparam int CNT_W = $clog2(CAP + 2);

  logic [CNT_W-1:0] cnt_r;
  logic             inc, dec;

  assign inc = in_tvalid && in_tready;
  assign dec = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (inc && !dec) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (dec && !inc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or vanished while stalled");

  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused while the output is empty");

  a_no_invented : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result offered with no request in flight");

  a_capacity : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("more requests in flight than the pipeline holds");

endmodule

bind mecanum_wheel_mixer_top mecw_checker #(
  .CMD_WIDTH (CMD_WIDTH)
) u_mecw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the mecanum wheel mixer
// A short table of velocity requests covers the field extremes, the limit
// edge cases and the unlimited negative wheels. Random requests then follow
// under several speed limits and handshake pressure patterns. Every result
// is checked field by field against a hand-worked value or the in-bench wheel mixing model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CMD_WIDTH = 14;
  localparam int LIMIT_W   = mecw_pkg::LIMIT_W;
  localparam int OUT_W     = mecw_pkg::OUT_W;
  localparam int IN_W      = ((3*CMD_WIDTH+7)/8)*8;
  localparam int PAD_W     = IN_W - 3*CMD_WIDTH;
  // Pipeline depth in registers, used only for the final wait.
  localparam int LATENCY   = CMD_WIDTH + 5;
  localparam int CHUNKS    = 5;
  localparam int CHUNK_LEN = 65;

  // One velocity request; vel_x sits in the lowest bits once packed.
  typedef struct packed {
    logic signed [CMD_WIDTH-1:0] vel_rot;
    logic signed [CMD_WIDTH-1:0] vel_y;
    logic signed [CMD_WIDTH-1:0] vel_x;
  } velocity_cmd_t;

  // One set of motor speeds, laid out exactly as {out_tuser, out_tdata}.
  typedef struct packed {
    logic                    was_scaled;
    logic signed [OUT_W-1:0] motor_four;
    logic signed [OUT_W-1:0] motor_three;
    logic signed [OUT_W-1:0] motor_two;
    logic signed [OUT_W-1:0] motor_one;
  } motor_speeds_t;

  // A row of the directed table. A row may first load a new speed limit, and
  // carries a hand-worked result where one is easy to read off.
  typedef struct packed {
    logic               load_limit;
    logic [LIMIT_W-1:0] limit;
    velocity_cmd_t      cmd;
    logic               has_known;
    motor_speeds_t      known;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [4*OUT_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [LIMIT_W-1:0]    cfg_wr_data;

  // Bench copy of the speed limit; only changed while the block is idle.
  logic [LIMIT_W-1:0]    limit_shadow;
  motor_speeds_t         pending_speeds[$];
  directed_row_t         directed_rows[$];
  int                    fail_count;
  int                    sender_idle_pct;
  int                    receiver_stall_pct;

  mecanum_wheel_mixer_top #(
    .CMD_WIDTH(CMD_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Wheel mixing model. The four mixes are formed at full width, the largest
  // is compared against the limit, and only a positive excess triggers the
  // rescale; division in SystemVerilog truncates toward zero as required.
  // Note the output order: motor three carries w4 and motor four carries w3.
  function automatic motor_speeds_t mix_wheels(velocity_cmd_t c, logic [LIMIT_W-1:0] lim);
    longint x, y, a, w1, w2, w3, w4, peak, l;
    motor_speeds_t r;
    x = longint'(c.vel_x);
    y = longint'(c.vel_y);
    a = longint'(c.vel_rot);
    l = longint'(lim);
    w1 = y - x - a;
    w2 = y + x + a;
    w3 = y - x + a;
    w4 = y + x - a;
    peak = w1;
    if (w2 > peak) peak = w2;
    if (w3 > peak) peak = w3;
    if (w4 > peak) peak = w4;
    r.was_scaled = (peak > l);
    if (r.was_scaled) begin
      w1 = (w1 * l) / peak;
      w2 = (w2 * l) / peak;
      w3 = (w3 * l) / peak;
      w4 = (w4 * l) / peak;
    end
    r.motor_one   = w1[OUT_W-1:0];
    r.motor_two   = w2[OUT_W-1:0];
    r.motor_three = w4[OUT_W-1:0];
    r.motor_four  = w3[OUT_W-1:0];
    return r;
  endfunction

  function automatic directed_row_t row(bit load, int lim, int x, int y, int a, bit known,
                                        int m1, int m2, int m3, int m4, bit sc);
    directed_row_t d;
    d.load_limit          = load;
    d.limit               = LIMIT_W'(lim);
    d.cmd.vel_x           = CMD_WIDTH'(x);
    d.cmd.vel_y           = CMD_WIDTH'(y);
    d.cmd.vel_rot         = CMD_WIDTH'(a);
    d.has_known           = known;
    d.known.motor_one     = OUT_W'(m1);
    d.known.motor_two     = OUT_W'(m2);
    d.known.motor_three   = OUT_W'(m3);
    d.known.motor_four    = OUT_W'(m4);
    d.known.was_scaled    = sc;
    return d;
  endfunction

  // Random request: half the time raw bits over the whole field range, the
  // rest of the time values near the current limit so that both the scaled
  // and the pass-through paths are well exercised.
  function automatic velocity_cmd_t random_command(logic [LIMIT_W-1:0] lim);
    velocity_cmd_t c;
    int span;
    if ($urandom_range(0, 1) == 0) begin
      c.vel_x   = CMD_WIDTH'($urandom);
      c.vel_y   = CMD_WIDTH'($urandom);
      c.vel_rot = CMD_WIDTH'($urandom);
    end else begin
      span = int'(lim) / 3 + 50;
      if (span > 8191) span = 8191;
      c.vel_x   = CMD_WIDTH'(int'($urandom_range(0, 2*span)) - span);
      c.vel_y   = CMD_WIDTH'(int'($urandom_range(0, 2*span)) - span);
      c.vel_rot = CMD_WIDTH'(int'($urandom_range(0, 2*span)) - span);
    end
    return c;
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ($urandom_range(0, 1) != 0) ? 15'd32767 : 15'd24576;
      2:       return 15'd1;
      default: return LIMIT_W'($urandom_range(1, 24576));
    endcase
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sends one request, idling beforehand at the current sender rate. The
  // valid is left high on acceptance so that back-to-back requests never
  // lower and raise it within the same time step.
  task automatic send_request(velocity_cmd_t c, bit has_known, motor_speeds_t known);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{PAD_W{1'b0}}, c};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_speeds.push_back(has_known ? known : mix_wheels(c, limit_shadow));
  endtask

  task automatic wait_for_drain();
    while (pending_speeds.size() != 0) @(posedge clk);
  endtask

  // The limit is only reloaded once the pipeline has emptied, so every
  // request in flight was predicted with the limit the block is using.
  task automatic load_speed_limit(logic [LIMIT_W-1:0] value);
    in_tvalid   <= 1'b0;
    wait_for_drain();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    limit_shadow  = value;
  endtask

  // Output side: stall at the phase's rate, sampled fresh every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Result checker: every accepted result is matched against the oldest
  // outstanding prediction; a result with nothing outstanding is a failure.
  always @(posedge clk) begin
    motor_speeds_t want;
    motor_speeds_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (pending_speeds.size() == 0) begin
        $error("unexpected result: motor_one %0d, was_scaled %0d", got.motor_one,
               got.was_scaled);
        fail_count++;
      end else begin
        want = pending_speeds.pop_front();
        check_field("motor_one", int'(want.motor_one), int'(got.motor_one));
        check_field("motor_two", int'(want.motor_two), int'(got.motor_two));
        check_field("motor_three", int'(want.motor_three), int'(got.motor_three));
        check_field("motor_four", int'(want.motor_four), int'(got.motor_four));
        check_field("was_scaled", int'(want.was_scaled), int'(got.was_scaled));
      end
    end
  end

  initial begin
    velocity_cmd_t c;
    motor_speeds_t none;
    int idle_modes [4][2];

    none               = '0;
    fail_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    limit_shadow       = mecw_pkg::LIMIT_RESET;
    rst_n              = 1'b0;
    in_tdata           = '0;
    in_tvalid          = 1'b0;
    out_tready         = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;

    // Directed table. The first rows run at the reset limit of 1000 and check
    // that it really is loaded by reset.
    directed_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    // Maximum equal to the limit passes through; one above it is scaled.
    directed_rows.push_back(row(0, 0, 0, 1000, 0, 1, 1000, 1000, 1000, 1000, 0));
    directed_rows.push_back(row(0, 0, 0, 1001, 0, 1, 1000, 1000, 1000, 1000, 1));
    // All wheels strongly negative: left unlimited.
    directed_rows.push_back(row(0, 0, 0, -8192, 0, 1, -8192, -8192, -8192, -8192, 0));
    // Largest possible w1, with the other wheels scaled and truncated.
    directed_rows.push_back(row(0, 0, -8192, 8191, -8192, 1, 1000, -333, 333, 333, 1));
    // Scaled case where a negative wheel ends up well below minus the limit.
    directed_rows.push_back(row(0, 0, 8191, -8192, 8191, 1, -3000, 1000, -1000, -1000, 1));
    directed_rows.push_back(row(0, 0, 700, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(0, 0, 0, 0, -700, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(0, 0, 8191, 8191, 8191, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(0, 0, -1, -1, -1, 0, 0, 0, 0, 0, 0));
    // Limit of zero: any positive maximum forces every wheel to zero.
    directed_rows.push_back(row(1, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1));
    directed_rows.push_back(row(0, 0, 0, -5, 0, 1, -5, -5, -5, -5, 0));
    directed_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(0, 0, -8192, -8192, -8192, 0, 0, 0, 0, 0, 0));
    // Limit of one.
    directed_rows.push_back(row(1, 1, 0, 8191, 0, 1, 1, 1, 1, 1, 1));
    directed_rows.push_back(row(0, 0, 1, 0, 0, 1, -1, 1, 1, -1, 0));
    directed_rows.push_back(row(0, 0, 3, 2, 1, 0, 0, 0, 0, 0, 0));
    // Top of the stated range: even the largest wheel passes unchanged.
    directed_rows.push_back(row(1, 24576, -8192, 8191, -8192, 1, 24575, -8193, 8191, 8191, 0));
    directed_rows.push_back(row(0, 0, -8192, 8191, 8191, 0, 0, 0, 0, 0, 0));
    // Largest value the register can hold.
    directed_rows.push_back(row(1, 32767, 8191, 8191, -8192, 0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_limit) load_speed_limit(directed_rows[i].limit);
      send_request(directed_rows[i].cmd, directed_rows[i].has_known, directed_rows[i].known);
    end

    // Random part: four pressure patterns, each split into chunks that run
    // under a fresh limit. Draining before each reload also makes the sender
    // wait for every outstanding result at least once per chunk.
    idle_modes = '{'{0, 0}, '{63, 0}, '{0, 63}, '{14, 14}};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_modes[p][0];
      receiver_stall_pct = idle_modes[p][1];
      for (int k = 0; k < CHUNKS; k++) begin
        load_speed_limit(random_limit());
        for (int n = 0; n < CHUNK_LEN; n++) begin
          c = random_command(limit_shadow);
          send_request(c, 1'b0, none);
        end
      end
    end

    in_tvalid <= 1'b0;
    receiver_stall_pct = 0;
    wait_for_drain();
    // Allow any stray extra result time to surface.
    repeat (2*LATENCY) @(posedge clk);

    if (fail_count == 0 && pending_speeds.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mecw_pkg.sv
hw/rtl/mecw_front.sv
hw/rtl/mecw_div_cell.sv
hw/rtl/mecw_skid.sv
hw/rtl/mecanum_wheel_mixer_top.sv
hw/rtl/mecw_checker.sv
tb/testbench.sv
